// ----- sv/clx_pkg.sv -----
// shared types and constants for the c subset lexer
// no dependencies
`timescale 1ns / 1ps

package clx_pkg;

  localparam int MAX_TEXT_BYTES_DEF = 65536;
  localparam int MAX_RES            = 3;
  localparam int RES_CNT_W          = $clog2(MAX_RES + 1);
  localparam int QDEPTH             = 4;

  typedef enum logic [2:0] {
    KIND_IDENT   = 3'd0,
    KIND_MARK    = 3'd1,
    KIND_KEYWORD = 3'd2,
    KIND_NUMBER  = 3'd3,
    KIND_END     = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] mark_code;
    logic [30:0] number_value;
    logic        overflowed;
    logic        last_result;
  } tok_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]  count;
    tok_t [MAX_RES-1:0]    tok;
  } step_t;

endpackage

// ----- sv/clx_if.sv -----
// valid/ready channel interfaces for lexer input bytes and result tokens
// no dependencies
`timescale 1ns / 1ps

interface clx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface clx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] mark_code;
  logic [30:0] number_value;
  logic        overflowed;
  logic        last_result;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output mark_code, output number_value,
                  output overflowed, output last_result, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input mark_code, input number_value,
                  input overflowed, input last_result, output ready);
endinterface

// ----- sv/clx_core.sv -----
// lexer state registers and the per-byte step logic, up to three tokens a byte
// depends on clx_pkg
`timescale 1ns / 1ps

module clx_core #(
  parameter int MAX_TEXT_BYTES = clx_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     text_byte,
  input  logic           is_last,
  output clx_pkg::step_t step
);
  import clx_pkg::*;

  localparam int PW = $clog2(MAX_TEXT_BYTES + 1);
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_TEXT_BYTES);
  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
  localparam logic [2:0]  KW_LEN = 3'd6;
  localparam logic [2:0]  KW_BROKEN = 3'd7;
  localparam logic [7:0]  CH_LT = 8'h3C;
  localparam logic [7:0]  CH_GT = 8'h3E;
  localparam logic [7:0]  CH_EQ = 8'h3D;
  localparam logic [7:0]  CH_BANG = 8'h21;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_MARK, M_ERROR
  } mode_t;

  typedef struct packed {
    logic  hit;
    tok_t  tok;
    mode_t mode;
  } flush_t;

  mode_t         mode_r, mode_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0]   begin_r, begin_nxt;
  logic [15:0]   run_r, run_nxt;
  logic [30:0]   acc_r, acc_nxt;
  logic          sat_r, sat_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic [2:0]    kw_r, kw_nxt;

  logic [7:0]           ch;
  logic                 consumed;
  logic [34:0]          num_sum;
  tok_t                 res [MAX_RES];
  logic [RES_CNT_W-1:0] nres;
  flush_t               fl;

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    unique case (idx)
      3'd0:    kw_char = 8'h72;
      3'd1:    kw_char = 8'h65;
      3'd2:    kw_char = 8'h74;
      3'd3:    kw_char = 8'h75;
      3'd4:    kw_char = 8'h72;
      3'd5:    kw_char = 8'h6E;
      default: kw_char = 8'h00;
    endcase
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_head(input logic [7:0] c);
    is_head = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
  endfunction

  function automatic logic is_pair_first(input logic [7:0] c);
    is_pair_first = (c == CH_LT) || (c == CH_GT) || (c == CH_EQ) || (c == CH_BANG);
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    is_single = (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
                (c == 8'h28) || (c == 8'h29) || (c == 8'h3B);
  endfunction

  function automatic logic [15:0] clamp16(input logic [PW-1:0] p);
    logic [PW+15:0] w;
    w = (PW + 16)'(p);
    clamp16 = (w > (PW + 16)'(65535)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input logic [15:0] s,
                                  input logic [15:0] l, input logic [15:0] code,
                                  input logic [30:0] v, input logic o);
    tok_t t;
    t.token_kind   = k;
    t.token_start  = s;
    t.token_length = l;
    t.mark_code    = code;
    t.number_value = v;
    t.overflowed   = o;
    t.last_result  = 1'b0;
    mk_tok = t;
  endfunction

  function automatic flush_t flush(input mode_t m, input logic [15:0] b,
                                   input logic [15:0] r, input logic [30:0] a,
                                   input logic s, input logic [7:0] p,
                                   input logic [2:0] k);
    flush_t f;
    f.hit  = 1'b0;
    f.tok  = mk_tok(KIND_END, 16'd0, 16'd0, 16'd0, 31'd0, 1'b0);
    f.mode = m;
    unique case (m)
      M_IDENT: begin
        f.hit  = 1'b1;
        f.tok  = mk_tok((k == KW_LEN) ? KIND_KEYWORD : KIND_IDENT, b, r, 16'd0,
                        31'd0, 1'b0);
        f.mode = M_IDLE;
      end
      M_NUMBER: begin
        f.hit  = 1'b1;
        f.tok  = mk_tok(KIND_NUMBER, b, r, 16'd0, a, s);
        f.mode = M_IDLE;
      end
      M_MARK: begin
        f.hit = 1'b1;
        if (p == CH_BANG) begin
          f.tok  = mk_tok(KIND_ERROR, b, 16'd1, 16'd0, 31'd0, 1'b0);
          f.mode = M_ERROR;
        end else begin
          f.tok  = mk_tok(KIND_MARK, b, 16'd1, {8'h00, p}, 31'd0, 1'b0);
          f.mode = M_IDLE;
        end
      end
      M_IDLE, M_ERROR: ;
      default: ;
    endcase
    flush = f;
  endfunction

  always_comb begin
    ch        = (pos_r >= MAX_POS) ? 8'h00 : text_byte;
    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    run_nxt   = run_r;
    acc_nxt   = acc_r;
    sat_nxt   = sat_r;
    pend_nxt  = pend_r;
    kw_nxt    = kw_r;
    consumed  = 1'b0;
    nres      = '0;
    num_sum   = {acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {27'd0, ch - 8'h30};
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = mk_tok(KIND_END, 16'd0, 16'd0, 16'd0, 31'd0, 1'b0);
    end

    if (mode_r != M_ERROR) begin
      if (mode_r == M_IDENT && (is_head(ch) || is_digit(ch))) begin
        if ((16'(kw_r) == run_r) && (run_r < 16'(KW_LEN)) && (ch == kw_char(run_r[2:0])))
          kw_nxt = kw_r + 3'd1;
        else
          kw_nxt = KW_BROKEN;
        run_nxt  = (run_r != 16'hFFFF) ? run_r + 16'd1 : run_r;
        consumed = 1'b1;
      end else if (mode_r == M_NUMBER && is_digit(ch)) begin
        run_nxt = (run_r != 16'hFFFF) ? run_r + 16'd1 : run_r;
        if (!sat_r) begin
          if (num_sum > {4'd0, NUM_MAX}) begin
            acc_nxt = NUM_MAX;
            sat_nxt = 1'b1;
          end else begin
            acc_nxt = num_sum[30:0];
          end
        end
        consumed = 1'b1;
      end else if (mode_r == M_MARK && ch == CH_EQ) begin
        res[nres] = mk_tok(KIND_MARK, begin_r, 16'd2, {CH_EQ, pend_r}, 31'd0, 1'b0);
        nres      = nres + 1'b1;
        mode_nxt  = M_IDLE;
        consumed  = 1'b1;
      end

      if (!consumed) begin
        fl = flush(mode_nxt, begin_nxt, run_nxt, acc_nxt, sat_nxt, pend_nxt, kw_nxt);
        if (fl.hit) begin
          res[nres] = fl.tok;
          nres      = nres + 1'b1;
        end
        mode_nxt = fl.mode;
        if (mode_nxt != M_ERROR && !is_space(ch)) begin
          begin_nxt = clamp16(pos_r);
          priority if (is_pair_first(ch)) begin
            pend_nxt = ch;
            mode_nxt = M_MARK;
          end else if (is_single(ch)) begin
            res[nres] = mk_tok(KIND_MARK, clamp16(pos_r), 16'd1, {8'h00, ch}, 31'd0, 1'b0);
            nres      = nres + 1'b1;
          end else if (is_head(ch)) begin
            run_nxt  = 16'd1;
            kw_nxt   = (ch == kw_char(3'd0)) ? 3'd1 : KW_BROKEN;
            mode_nxt = M_IDENT;
          end else if (is_digit(ch)) begin
            run_nxt  = 16'd1;
            acc_nxt  = 31'(ch - 8'h30);
            sat_nxt  = 1'b0;
            mode_nxt = M_NUMBER;
          end else begin
            res[nres] = mk_tok(KIND_ERROR, clamp16(pos_r), 16'd1, 16'd0, 31'd0, 1'b0);
            nres      = nres + 1'b1;
            mode_nxt  = M_ERROR;
          end
        end
      end
    end

    pos_nxt = (pos_r < MAX_POS) ? pos_r + 1'b1 : pos_r;

    if (is_last) begin
      fl = flush(mode_nxt, begin_nxt, run_nxt, acc_nxt, sat_nxt, pend_nxt, kw_nxt);
      if (fl.hit) begin
        res[nres] = fl.tok;
        nres      = nres + 1'b1;
      end
      res[nres] = mk_tok(KIND_END, clamp16(pos_nxt), 16'd0, 16'd0, 31'd0, 1'b0);
      nres      = nres + 1'b1;
      mode_nxt  = M_IDLE;
      pos_nxt   = '0;
      begin_nxt = '0;
      run_nxt   = '0;
      acc_nxt   = '0;
      sat_nxt   = 1'b0;
      pend_nxt  = '0;
      kw_nxt    = '0;
    end else begin
      fl = flush(M_IDLE, begin_nxt, run_nxt, acc_nxt, sat_nxt, pend_nxt, kw_nxt);
    end

    if (nres != '0) begin
      res[nres - 1'b1].last_result = 1'b1;
    end

    step.count = nres;
    for (int i = 0; i < MAX_RES; i++) begin
      step.tok[i] = res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      begin_r <= '0;
      run_r   <= '0;
      acc_r   <= '0;
      sat_r   <= 1'b0;
      pend_r  <= '0;
      kw_r    <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
      run_r   <= run_nxt;
      acc_r   <= acc_nxt;
      sat_r   <= sat_nxt;
      pend_r  <= pend_nxt;
      kw_r    <= kw_nxt;
    end
  end

  // last byte returns the lexer to its starting state
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_last |=> pos_r == '0 && mode_r == M_IDLE)
    else $error("state not cleared after last byte");

  // the end token is always produced on the last byte
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    is_last |-> step.count != '0)
    else $error("no end token on last byte");

  a_pend_char: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_MARK |-> pend_r == CH_LT || pend_r == CH_GT || pend_r == CH_EQ ||
                         pend_r == CH_BANG)
    else $error("pending mark char is not a pair opener");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAX_POS)
    else $error("byte position past limit");

endmodule

// ----- sv/clx_queue.sv -----
// result token queue: takes up to three tokens per transfer, hands out one a cycle while the receiver is ready
// depends on clx_pkg
`timescale 1ns / 1ps

module clx_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  clx_pkg::step_t step,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output clx_pkg::tok_t  head
);
  import clx_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  tok_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] push_n;
  logic             pop;

  assign push_n    = push ? CNT_W'(step.count) : '0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign in_ready  = (cnt_r <= CNT_W'(QDEPTH - MAX_RES));
  assign head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PTR_W'(push_n);
      if (pop)
        rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + push_n - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (push && (i < int'(step.count)))
        mem_r[PTR_W'(wr_r + PTR_W'(i))] <= step.tok[i];
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QDEPTH))
    else $error("token queue overfilled");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> cnt_r == $past(cnt_r) + $past(push_n) - CNT_W'($past(pop)))
    else $error("token queue count mismatch");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> in_ready)
    else $error("transfer into full token queue");

endmodule

// ----- sv/c_subset_lexer.sv -----
// Streaming lexer for a small C subset: one text byte per transfer in, one token
// per transfer out. A byte is taken every cycle while the 4-entry token queue
// holds at most one token; each byte is classified and the lexer state updated
// in the cycle of its transfer, and its tokens (none, one or two, or up to three
// on the last byte) leave the queue one per cycle while the receiver is ready.
// No clearing pass after reset. Sustained rate is one byte per cycle, limited by
// receiver stalls and the single token output port on multi-token bytes.
// depends on clx_pkg, clx_if, clx_core, clx_queue
`timescale 1ns / 1ps

module c_subset_lexer #(
  parameter int MAX_TEXT_BYTES = clx_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  clx_in_if.sink     in_ch,
  clx_out_if.source  out_ch
);
  import clx_pkg::*;

  logic  accept;
  step_t step;
  tok_t  head;
  logic  ready;

  assign accept      = in_ch.valid && ready;
  assign in_ch.ready = ready;

  clx_core #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_ch.text_byte),
    .is_last   (in_ch.is_last),
    .step      (step)
  );

  clx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .step      (step),
    .in_ready  (ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .head      (head)
  );

  assign out_ch.token_kind   = head.token_kind;
  assign out_ch.token_start  = head.token_start;
  assign out_ch.token_length = head.token_length;
  assign out_ch.mark_code    = head.mark_code;
  assign out_ch.number_value = head.number_value;
  assign out_ch.overflowed   = head.overflowed;
  assign out_ch.last_result  = head.last_result;

endmodule

// ----- tb/sv/clx_token_checker.sv -----
// token checker for the c subset lexer: rebuilds the token stream from every
// accepted text byte and compares each result transfer with the oldest token due
// depends on clx_pkg and clx_if
`timescale 1ns / 1ps

module clx_token_checker #(
  parameter int MAX_BYTES = clx_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  clx_in_if    in_ch,
  clx_out_if   out_ch,
  output int   mismatches,
  output int   tokens_due
);
  import clx_pkg::*;

  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_NUMBER, LX_MARK, LX_ERROR
  } lex_mode_t;

  localparam logic [2:0]  KW_FULL  = 3'd6;
  localparam logic [2:0]  KW_MISS  = 3'd7;
  localparam logic [30:0] NUM_CEIL = 31'h7FFF_FFFF;

  string       kw_word = "return";
  lex_mode_t   mode_r;
  logic [20:0] pos_r;
  logic [20:0] begin_r;
  logic [15:0] run_r;
  logic [30:0] acc_r;
  logic        sat_r;
  logic [7:0]  mark_r;
  logic [2:0]  kw_r;

  tok_t step_toks[$];
  tok_t due_q[$];
  tok_t got;
  tok_t want;
  int   bad_cnt;

  function automatic logic [15:0] sat16(input logic [20:0] x);
    return (x > 21'd65535) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic bit is_head(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_tok(input kind_t k, input logic [20:0] st,
                                  input logic [20:0] len, input logic [15:0] code,
                                  input logic [30:0] val, input logic ovf);
    tok_t t;
    if (step_toks.size() >= MAX_RES) return;
    t.token_kind   = k;
    t.token_start  = sat16(st);
    t.token_length = sat16(len);
    t.mark_code    = code;
    t.number_value = val;
    t.overflowed   = ovf;
    t.last_result  = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void clear_state();
    mode_r  = LX_IDLE;
    pos_r   = '0;
    begin_r = '0;
    run_r   = '0;
    acc_r   = '0;
    sat_r   = 1'b0;
    mark_r  = '0;
    kw_r    = '0;
  endfunction

  // closes the open token; a lone bang turns into an error
  function automatic void close_open();
    case (mode_r)
      LX_IDENT: begin
        if (kw_r == KW_FULL) add_tok(KIND_KEYWORD, begin_r, 21'(run_r), 0, 0, 0);
        else add_tok(KIND_IDENT, begin_r, 21'(run_r), 0, 0, 0);
        mode_r = LX_IDLE;
      end
      LX_NUMBER: begin
        add_tok(KIND_NUMBER, begin_r, 21'(run_r), 0, acc_r, sat_r);
        mode_r = LX_IDLE;
      end
      LX_MARK: begin
        if (mark_r == "!") begin
          add_tok(KIND_ERROR, begin_r, 1, 0, 0, 0);
          mode_r = LX_ERROR;
        end else begin
          add_tok(KIND_MARK, begin_r, 1, {8'h00, mark_r}, 0, 0);
          mode_r = LX_IDLE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void lex_byte(input logic [7:0] raw, input logic last);
    logic [7:0]  c;
    logic [20:0] p;
    logic [34:0] wide;
    bit          took;
    c    = raw;
    p    = pos_r;
    took = 1'b0;
    step_toks.delete();
    if (p >= MAX_BYTES) c = 8'h00;
    if (mode_r != LX_ERROR) begin
      if (mode_r == LX_IDENT && (is_head(c) || is_digit(c))) begin
        if (16'(kw_r) == run_r && run_r < 16'd6 && c == kw_word[run_r]) kw_r = kw_r + 3'd1;
        else kw_r = KW_MISS;
        if (run_r != 16'hFFFF) run_r = run_r + 16'd1;
        took = 1'b1;
      end else if (mode_r == LX_NUMBER && is_digit(c)) begin
        if (run_r != 16'hFFFF) run_r = run_r + 16'd1;
        if (!sat_r) begin
          wide = 35'(acc_r) * 35'd10 + 35'(c - 8'h30);
          if (wide > 35'(NUM_CEIL)) begin
            acc_r = NUM_CEIL;
            sat_r = 1'b1;
          end else begin
            acc_r = wide[30:0];
          end
        end
        took = 1'b1;
      end else if (mode_r == LX_MARK && c == "=") begin
        add_tok(KIND_MARK, begin_r, 2, {8'h3D, mark_r}, 0, 0);
        mode_r = LX_IDLE;
        took   = 1'b1;
      end
      if (!took) begin
        close_open();
        if (mode_r != LX_ERROR && !(c inside {8'd32, [8'd9:8'd13]})) begin
          begin_r = p;
          if (c inside {"<", ">", "=", "!"}) begin
            mark_r = c;
            mode_r = LX_MARK;
          end else if (c inside {"+", "-", "*", "/", "(", ")", ";"}) begin
            add_tok(KIND_MARK, p, 1, {8'h00, c}, 0, 0);
          end else if (is_head(c)) begin
            run_r  = 16'd1;
            kw_r   = (c == "r") ? 3'd1 : KW_MISS;
            mode_r = LX_IDENT;
          end else if (is_digit(c)) begin
            run_r  = 16'd1;
            acc_r  = 31'(c - 8'h30);
            sat_r  = 1'b0;
            mode_r = LX_NUMBER;
          end else begin
            add_tok(KIND_ERROR, p, 1, 0, 0, 0);
            mode_r = LX_ERROR;
          end
        end
      end
    end
    if (p < MAX_BYTES) p = p + 21'd1;
    pos_r = p;
    if (last) begin
      close_open();
      add_tok(KIND_END, p, 0, 0, 0, 0);
      clear_state();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_result = 1'b1;
    foreach (step_toks[i]) due_q.push_back(step_toks[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      due_q.delete();
      bad_cnt = 0;
      mismatches <= 0;
      tokens_due <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) lex_byte(in_ch.text_byte, in_ch.is_last);
      if (out_ch.valid && out_ch.ready) begin
        got.token_kind   = kind_t'(out_ch.token_kind);
        got.token_start  = out_ch.token_start;
        got.token_length = out_ch.token_length;
        got.mark_code    = out_ch.mark_code;
        got.number_value = out_ch.number_value;
        got.overflowed   = out_ch.overflowed;
        got.last_result  = out_ch.last_result;
        if (due_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("%0t: unexpected token kind %0d start %0d len %0d", $time,
                     got.token_kind, got.token_start, got.token_length);
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("%0t: token mismatch", $time);
              $display("  want kind %0d start %0d len %0d code %h val %0d ovf %0b last %0b",
                       want.token_kind, want.token_start, want.token_length,
                       want.mark_code, want.number_value, want.overflowed,
                       want.last_result);
              $display("  got  kind %0d start %0d len %0d code %h val %0d ovf %0b last %0b",
                       got.token_kind, got.token_start, got.token_length,
                       got.mark_code, got.number_value, got.overflowed,
                       got.last_result);
            end
          end
        end
      end
      mismatches <= bad_cnt;
      tokens_due <= due_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_c_subset_lexer.sv -----
// top of the c subset lexer testbench: clock, reset, text stimulus in bursts,
// a stalling token receiver, an idle watchdog and the verdict
// depends on clx_pkg, clx_if, c_subset_lexer and clx_token_checker
`timescale 1ns / 1ps

module tb_c_subset_lexer;
  import clx_pkg::*;

  localparam int TEXT_MAX     = 256;
  localparam int RANDOM_BYTES = 120;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic [7:0] rx_phase;
  int         mismatches;
  int         tokens_due;
  int         idle_cycles = 0;
  int         random_sent;
  text_item_t text_q[$];
  string      id_chars     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string      single_marks = "+-*/();";
  string      pair_heads   = "<>=!";

  clx_in_if  in_ch ();
  clx_out_if out_ch ();

  c_subset_lexer #(.MAX_TEXT_BYTES(TEXT_MAX)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  clx_token_checker #(.MAX_BYTES(TEXT_MAX)) tok_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .tokens_due (tokens_due)
  );

  always #5 clk = ~clk;

  task automatic queue_byte(input logic [7:0] ch, input logic last);
    text_item_t t;
    t.ch   = ch;
    t.last = last;
    text_q.push_back(t);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'd32 : 8'(9 + k);
  endfunction

  // mostly well-formed tokens; a noisy text also carries random bytes
  task automatic make_text(input int n_tok, input int min_len);
    logic [7:0] chars[$];
    string      w;
    int         t;
    int         k;
    int         n;
    bit         noisy;
    noisy = ($urandom_range(0, 4) == 0);
    t = 0;
    while (t < n_tok || chars.size() < min_len) begin
      case ($urandom_range(0, 5))
        0: begin
          k = $urandom_range(0, 5);
          if (k < 3) begin
            w = (k == 0) ? "return" : (k == 1) ? "retur" : "returned";
            for (int i = 0; i < w.len(); i++) chars.push_back(w[i]);
          end else begin
            n = $urandom_range(1, 6);
            chars.push_back(id_chars[$urandom_range(0, 52)]);
            for (int i = 1; i < n; i++) chars.push_back(id_chars[$urandom_range(0, 62)]);
          end
        end
        1: begin
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
          for (int i = 0; i < n; i++) chars.push_back(8'(8'h30 + $urandom_range(0, 9)));
        end
        2: chars.push_back(single_marks[$urandom_range(0, 6)]);
        3: begin
          chars.push_back(pair_heads[$urandom_range(0, 3)]);
          if ($urandom_range(0, 1) == 0) chars.push_back("=");
        end
        4: begin
          // digits running straight into an identifier
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) chars.push_back(8'(8'h30 + $urandom_range(0, 9)));
          chars.push_back(id_chars[$urandom_range(0, 52)]);
        end
        default: begin
          if (noisy) chars.push_back(8'($urandom_range(0, 255)));
          else chars.push_back(pick_space());
        end
      endcase
      if ($urandom_range(0, 1) == 0) chars.push_back(pick_space());
      if (noisy && $urandom_range(0, 5) == 0) chars.push_back(8'($urandom_range(0, 255)));
      t++;
    end
    foreach (chars[i]) queue_byte(chars[i], i == chars.size() - 1);
    random_sent += chars.size();
  endtask

  task automatic send_queued();
    text_item_t item;
    int         burst;
    int         gap;
    while (text_q.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && text_q.size() > 0) begin
        item = text_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.text_byte <= item.ch;
        in_ch.is_last   <= item.last;
        do @(posedge clk); while (!in_ch.ready);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (tokens_due != 0);
  endtask

  // receiver: a long stall, free-running stretches and random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase     <= '0;
      out_ch.ready <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 8'd1;
      if (rx_phase[7:5] == 3'd3) out_ch.ready <= 1'b0;
      else if (rx_phase[6]) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d tokens due", idle_cycles,
               tokens_due);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    random_sent     = 0;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = 8'h00;
    in_ch.is_last   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // keyword, two-char mark, number
    queue_text("return<=9");
    // lone bang swallows the rest of the text
    queue_text("a!x");
    // number then letter, trailing mark flushed by the last byte
    queue_text("7b>");
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_text("!");
    queue_text("!=;");
    queue_text(" ");
    send_queued();
    wait_drained();

    while (random_sent < RANDOM_BYTES / 2) make_text($urandom_range(1, 6), 0);
    send_queued();
    wait_drained();

    while (random_sent < RANDOM_BYTES) make_text($urandom_range(1, 6), 0);
    send_queued();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && tokens_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
